// File: rtl/ntlv_pkg.sv
// ----------------------------------------------------------------------------
// ntlv_pkg
// Shared types and constants for the nested TLV stream parser: the level cell
// command and status groups and the result record carried to the output.
// ----------------------------------------------------------------------------
package ntlv_pkg;

  // width of a level byte count and of a record body length
  localparam int LVL_W = 24;

  // command broadcast to every level cell for one transfer
  typedef struct packed {
    logic             flush;      // new file: close all levels before this byte
    logic             top_we;     // write top level count
    logic [LVL_W-1:0] top_wdata;
    logic             push;       // open a new level above the top
    logic [LVL_W-1:0] push_data;
    logic             done;       // record ended: close exhausted levels
  } level_cmd_t;

  // status a level cell shows to its neighbors and to the controller
  typedef struct packed {
    logic             open;       // level open (after flush)
    logic             survive;    // this or a higher level stays open after close
    logic [LVL_W-1:0] top_val;    // count when this cell is the top, else zero
  } level_stat_t;

  // one result item
  typedef struct packed {
    logic [2:0]       role;
    logic [7:0]       rtype;
    logic [LVL_W-1:0] rlen;
    logic [3:0]       depth;
    logic [15:0]      obj;
    logic [7:0]       pay;
    logic             last;
    logic             ann;
    logic [1:0]       status;
  } res_t;

endpackage

// File: rtl/ntlv_level_cell.sv
// ----------------------------------------------------------------------------
// ntlv_level_cell
// One nesting level: holds the bytes left in that level and an open bit.
// Finds from its neighbors whether it is the top or the next free slot.
// ----------------------------------------------------------------------------
module ntlv_level_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  ntlv_pkg::level_cmd_t cmd,
  input  logic                 open_above,
  input  logic                 open_below,
  input  logic                 survive_above,
  output ntlv_pkg::level_stat_t stat
);
  import ntlv_pkg::*;

  logic             open_q;
  logic [LVL_W-1:0] val_q;
  logic             open_eff;
  logic             is_top;
  logic             is_slot;
  logic [LVL_W-1:0] val_next;
  logic             open_new;
  logic             survive;

  always_comb begin
    open_eff = open_q && !cmd.flush;
    is_top   = open_eff && !open_above;
    is_slot  = !open_eff && open_below;
    val_next = val_q;
    open_new = open_eff;
    if (is_top && cmd.top_we) begin
      val_next = cmd.top_wdata;
    end
    if (is_slot && cmd.push) begin
      val_next = cmd.push_data;
      open_new = 1'b1;
    end
    // a level stays open if it or any level above it still has bytes left
    survive = (open_new && (val_next != '0)) || survive_above;
  end

  assign stat.open    = open_eff;
  assign stat.survive = survive;
  assign stat.top_val = is_top ? val_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_q <= 1'b0;
    end else if (cmd.done) begin
      open_q <= survive;
    end else begin
      open_q <= open_new;
    end
  end

  always_ff @(posedge clk) begin
    val_q <= val_next;
  end

endmodule

// File: rtl/ntlv_out_skid.sv
// ----------------------------------------------------------------------------
// ntlv_out_skid
// Output register with one skid entry for the result stream.
// ----------------------------------------------------------------------------
module ntlv_out_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ntlv_pkg::res_t in_res,
  output logic           out_valid,
  input  logic           out_ready,
  output ntlv_pkg::res_t out_res
);
  import ntlv_pkg::*;

  logic skid_valid;
  res_t skid_res;
  logic accept;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= in_res;
      end
    end else if (accept) begin
      skid_res <= in_res;
    end
  end

endmodule

// File: rtl/nested_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// nested_tlv_stream_parser
// Byte-wide parser for a headered file of nested type-length-value records.
//
//   channel  dir  fields
//   s_*      in   tdata: data_byte; tuser: file_start
//   m_*      out  tuser: byte_role; tlast: payload_last; tdata: record_type,
//                 record_length, nest_depth, object_number, payload_byte,
//                 record_announce, status
//
// One byte per cycle while s_tready is high; each result is registered before
// it shows on m_*. The level stack is a row of MAX_DEPTH cells updated in the
// same cycle, with exhausted levels closed through a ripple across the row.
// A two-entry output stage (register plus skid) holds results while m_tready
// is low; s_tready drops only when both entries are full.
// rst is synchronous and clears the parser, all levels and the output stage;
// the object counter restarts at one.
// ----------------------------------------------------------------------------
module nested_tlv_stream_parser #(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] file_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [7:0] record_type, [31:8] record_length,
                                 // [35:32] nest_depth, [51:36] object_number,
                                 // [59:52] payload_byte, [60] record_announce,
                                 // [62:61] status, [63] zero
  output logic [2:0]  m_tuser,   // [2:0] byte_role
  output logic        m_tlast    // payload_last
);
  import ntlv_pkg::*;

  localparam int OLW = $clog2(MAX_DEPTH + 1);

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_PAD1    = 3'd1;
  localparam logic [2:0] ROLE_TYPE    = 3'd2;
  localparam logic [2:0] ROLE_LEN     = 3'd3;
  localparam logic [2:0] ROLE_DATE    = 3'd4;
  localparam logic [2:0] ROLE_SKIP    = 3'd5;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd6;
  localparam logic [2:0] ROLE_IGNORED = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MAGIC   = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;
  localparam logic [1:0] ST_NEST    = 2'd3;

  localparam logic [7:0] MAGIC_BYTE   = 8'd53;
  localparam logic [7:0] VERSION_BYTE = 8'd0;
  localparam logic [7:0] T_PAD1       = 8'd0;
  localparam logic [7:0] T_TEXT       = 8'd2;
  localparam logic [7:0] T_JPEG       = 8'd4;
  localparam logic [7:0] T_COMPOUND   = 8'd5;
  localparam logic [7:0] T_DATED      = 8'd6;
  localparam logic [LVL_W-1:0] DATE_BYTES = LVL_W'(4);

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_TYPE    = 7'b0000010,
    PH_LEN     = 7'b0000100,
    PH_DATE    = 7'b0001000,
    PH_SKIP    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_ERROR   = 7'b1000000
  } phase_t;

  phase_t           phase, phase_e, phase_next;
  logic [1:0]       fc, fc_e, fc_next, fc_inc;
  logic [7:0]       cur_type, type_e, type_next;
  logic [LVL_W-1:0] acc, acc_e, acc_next, acc_new;
  logic [LVL_W-1:0] br, br_e, br_next, br_dec;
  logic [OLW-1:0]   ol, ol_e, ol_next, ol_enc;
  logic [15:0]      objcnt, objcnt_next;
  logic [1:0]       err, err_e, err_next;

  logic             in_acc;
  logic             res_ready;
  logic             file_start;
  logic             inner;
  logic             nests;
  logic             is_object;
  logic [LVL_W-1:0] top_val;
  logic [LVL_W-1:0] top_dec;
  level_cmd_t       cmd;
  level_stat_t      stat [MAX_DEPTH];
  logic [MAX_DEPTH:0] surv;
  res_t             res;
  res_t             out_res;

  assign s_tready   = res_ready;
  assign in_acc     = s_tvalid && res_ready;
  assign file_start = s_tuser;

  // level row
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic open_above;
    logic open_below;
    if (i == MAX_DEPTH - 1) begin : g_last
      assign open_above = 1'b0;
    end else begin : g_mid
      assign open_above = stat[i+1].open;
    end
    if (i == 0) begin : g_first
      assign open_below = 1'b1;
    end else begin : g_rest
      assign open_below = stat[i-1].open;
    end
    ntlv_level_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .open_above    (open_above),
      .open_below    (open_below),
      .survive_above (surv[i+1]),
      .stat          (stat[i])
    );
    assign surv[i] = stat[i].survive;
  end
  assign surv[MAX_DEPTH] = 1'b0;

  always_comb begin
    top_val = '0;
    ol_enc  = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      top_val = top_val | stat[i].top_val;
      if (surv[i] && !surv[i+1]) begin
        ol_enc = ol_enc | OLW'(i + 1);
      end
    end
  end

  always_comb begin
    // state as seen by this byte: a new file starts from a clean parser
    phase_e = file_start ? PH_HEADER : phase;
    fc_e    = file_start ? 2'd0 : fc;
    type_e  = file_start ? 8'd0 : cur_type;
    acc_e   = file_start ? '0 : acc;
    br_e    = file_start ? '0 : br;
    ol_e    = file_start ? '0 : ol;
    err_e   = file_start ? ST_OK : err;

    phase_next  = phase_e;
    fc_next     = fc_e;
    type_next   = type_e;
    acc_next    = acc_e;
    br_next     = br_e;
    objcnt_next = objcnt;
    err_next    = err_e;

    inner     = (ol_e != '0);
    nests     = (type_e == T_COMPOUND) || (type_e == T_DATED);
    is_object = (type_e >= T_TEXT) && (type_e <= T_JPEG);
    fc_inc    = fc_e + 2'd1;
    acc_new   = {acc_e[LVL_W-9:0], s_tdata};
    br_dec    = (br_e != '0) ? br_e - LVL_W'(1) : br_e;
    top_dec   = inner ? top_val - LVL_W'(1) : top_val;

    cmd.flush     = file_start;
    cmd.top_we    = 1'b0;
    cmd.top_wdata = top_dec;
    cmd.push      = 1'b0;
    cmd.push_data = acc_new;
    cmd.done      = 1'b0;

    res.role  = ROLE_IGNORED;
    res.rtype = 8'd0;
    res.rlen  = '0;
    res.depth = 4'(ol_e);
    res.obj   = 16'd0;
    res.pay   = 8'd0;
    res.last  = 1'b0;
    res.ann   = 1'b0;

    unique case (phase_e)
      PH_HEADER: begin
        res.role = ROLE_HEADER;
        if (fc_e == 2'd0 && s_tdata != MAGIC_BYTE) begin
          err_next   = ST_MAGIC;
          phase_next = PH_ERROR;
        end else if (fc_e == 2'd1 && s_tdata != VERSION_BYTE) begin
          err_next   = ST_VERSION;
          phase_next = PH_ERROR;
        end else if (fc_e == 2'd3) begin
          fc_next    = 2'd0;
          phase_next = PH_TYPE;
        end else begin
          fc_next = fc_inc;
        end
      end
      PH_TYPE: begin
        if (inner && top_val != '0) begin
          cmd.top_we = 1'b1;
        end
        if (s_tdata == T_PAD1) begin
          res.role   = ROLE_PAD1;
          type_next  = T_PAD1;
          cmd.done   = 1'b1;
          phase_next = PH_TYPE;
        end else begin
          res.role   = ROLE_TYPE;
          res.rtype  = s_tdata;
          type_next  = s_tdata;
          acc_next   = '0;
          fc_next    = 2'd0;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        res.role  = ROLE_LEN;
        res.rtype = type_e;
        if (inner && top_val == '0) begin
          err_next   = ST_NEST;
          phase_next = PH_ERROR;
        end else begin
          cmd.top_we = inner;
          acc_next   = acc_new;
          res.rlen   = acc_new;
          fc_next    = fc_inc;
          if (fc_e == 2'd2) begin
            res.ann = 1'b1;
            fc_next = 2'd0;
            if ((inner && acc_new > top_dec) ||
                (nests && ol_e >= OLW'(MAX_DEPTH)) ||
                (type_e == T_DATED && acc_new < DATE_BYTES)) begin
              err_next   = ST_NEST;
              phase_next = PH_ERROR;
            end else begin
              cmd.top_wdata = top_dec - acc_new;
              if (is_object) begin
                res.obj     = objcnt;
                objcnt_next = objcnt + 16'd1;
                br_next     = acc_new;
                if (acc_new == '0) begin
                  cmd.done   = 1'b1;
                  phase_next = PH_TYPE;
                end else begin
                  phase_next = PH_PAYLOAD;
                end
              end else if (type_e == T_COMPOUND) begin
                cmd.push   = 1'b1;
                cmd.done   = 1'b1;
                phase_next = PH_TYPE;
              end else if (type_e == T_DATED) begin
                br_next    = acc_new - DATE_BYTES;
                phase_next = PH_DATE;
              end else begin
                br_next = acc_new;
                if (acc_new == '0) begin
                  cmd.done   = 1'b1;
                  phase_next = PH_TYPE;
                end else begin
                  phase_next = PH_SKIP;
                end
              end
            end
          end
        end
      end
      PH_DATE: begin
        res.role      = ROLE_DATE;
        res.rtype     = type_e;
        res.rlen      = acc_e;
        fc_next       = fc_inc;
        cmd.push_data = br_e;
        if (fc_e == 2'd3) begin
          cmd.push   = 1'b1;
          cmd.done   = 1'b1;
          phase_next = PH_TYPE;
        end
      end
      PH_SKIP: begin
        res.role  = ROLE_SKIP;
        res.rtype = type_e;
        res.rlen  = acc_e;
        br_next   = br_dec;
        if (br_dec == '0) begin
          cmd.done   = 1'b1;
          phase_next = PH_TYPE;
        end
      end
      PH_PAYLOAD: begin
        res.role  = ROLE_PAYLOAD;
        res.rtype = type_e;
        res.rlen  = acc_e;
        res.obj   = objcnt - 16'd1;
        res.pay   = s_tdata;
        br_next   = br_dec;
        if (br_dec == '0) begin
          res.last   = 1'b1;
          cmd.done   = 1'b1;
          phase_next = PH_TYPE;
        end
      end
      default: begin
        res.role   = ROLE_IGNORED;
        phase_next = PH_ERROR;
      end
    endcase

    res.status = err_next;
    ol_next    = cmd.done ? ol_enc : ol_e;

    // hold the level row when no transfer takes place
    if (!in_acc) begin
      cmd.flush  = 1'b0;
      cmd.top_we = 1'b0;
      cmd.push   = 1'b0;
      cmd.done   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      fc       <= 2'd0;
      cur_type <= 8'd0;
      acc      <= '0;
      br       <= '0;
      ol       <= '0;
      objcnt   <= 16'd1;
      err      <= ST_OK;
    end else if (in_acc) begin
      phase    <= phase_next;
      fc       <= fc_next;
      cur_type <= type_next;
      acc      <= acc_next;
      br       <= br_next;
      ol       <= ol_next;
      objcnt   <= objcnt_next;
      err      <= err_next;
    end
  end

  ntlv_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.role;
  assign m_tlast = out_res.last;
  assign m_tdata = {1'b0, out_res.status, out_res.ann, out_res.pay, out_res.obj,
                    out_res.depth, out_res.rlen, out_res.rtype};

endmodule
